### design/slc_pkg.sv
// Shared types, codes and next-state functions for the scalar literal classifier.
package slc_pkg;

    localparam int MAG_W = 35;

    localparam logic [MAG_W-1:0] MAG_MAX     = {MAG_W{1'b1}};
    localparam logic [MAG_W-1:0] INT_POS_LIM = MAG_W'(36'h07FFFFFFF);
    localparam logic [MAG_W-1:0] INT_NEG_LIM = MAG_W'(36'h080000000);

    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_N     = 8'h6E;

    localparam logic [2:0] CLS_NONE   = 3'd0;
    localparam logic [2:0] CLS_CHAR   = 3'd1;
    localparam logic [2:0] CLS_INT    = 3'd2;
    localparam logic [2:0] CLS_FLOAT  = 3'd3;
    localparam logic [2:0] CLS_DOUBLE = 3'd4;

    localparam logic [1:0] NS_START = 2'd0;
    localparam logic [1:0] NS_INT   = 2'd1;
    localparam logic [1:0] NS_FRAC  = 2'd2;
    localparam logic [1:0] NS_DEAD  = 2'd3;

    localparam logic [2:0] PS_START = 3'd0;
    localparam logic [2:0] PS_INT   = 3'd1;
    localparam logic [2:0] PS_DOT   = 3'd2;
    localparam logic [2:0] PS_FRAC  = 3'd3;
    localparam logic [2:0] PS_DEAD  = 3'd4;

    localparam logic [3:0] WM_START = 4'd0;
    localparam logic [3:0] WM_N     = 4'd1;
    localparam logic [3:0] WM_NA    = 4'd2;
    localparam logic [3:0] WM_NAN   = 4'd3;
    localparam logic [3:0] WM_NANF  = 4'd4;
    localparam logic [3:0] WM_SIGN  = 4'd5;
    localparam logic [3:0] WM_I     = 4'd6;
    localparam logic [3:0] WM_IN    = 4'd7;
    localparam logic [3:0] WM_INF   = 4'd8;
    localparam logic [3:0] WM_INFF  = 4'd9;
    localparam logic [3:0] WM_DEAD  = 4'd10;

    // View of the scan state after the current character (prefix state before it)
    typedef struct packed {
        logic             len_one;
        logic             len_three;
        logic             len_fits_int;
        logic             first_was_quote;
        logic             first_was_digit;
        logic             third_was_quote;
        logic             negative_sign;
        logic [MAG_W-1:0] magnitude;
        logic             int_shape_ok;
        logic [1:0]       number_state;
        logic [2:0]       prefix_before;
        logic [3:0]       word_state;
        logic             is_f;
    } scan_t;

    function automatic logic [1:0] next_number(input logic [1:0] s, input logic dig,
                                               input logic sgn, input logic dot);
        logic [1:0] n;
        n = NS_DEAD;
        unique case (s)
            NS_START: n = (dig || sgn) ? NS_INT : (dot ? NS_FRAC : NS_DEAD);
            NS_INT:   n = dig ? NS_INT : (dot ? NS_FRAC : NS_DEAD);
            NS_FRAC:  n = dig ? NS_FRAC : NS_DEAD;
            default:  n = NS_DEAD;
        endcase
        return n;
    endfunction

    function automatic logic [2:0] next_prefix(input logic [2:0] s, input logic dig,
                                               input logic sgn, input logic dot);
        logic [2:0] n;
        n = PS_DEAD;
        unique case (s)
            PS_START: n = (dig || sgn) ? PS_INT : (dot ? PS_DOT : PS_DEAD);
            PS_INT:   n = dig ? PS_INT : (dot ? PS_DOT : PS_DEAD);
            PS_DOT:   n = dig ? PS_FRAC : PS_DEAD;
            PS_FRAC:  n = dig ? PS_FRAC : PS_DEAD;
            default:  n = PS_DEAD;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] next_word(input logic [3:0] s, input logic [7:0] c);
        logic [3:0] n;
        n = WM_DEAD;
        unique case (s)
            WM_START:
            begin
                if (c == CH_N)
                    n = WM_N;
                else if (c == CH_I)
                    n = WM_I;
                else if (c == CH_PLUS || c == CH_MINUS)
                    n = WM_SIGN;
                else
                    n = WM_DEAD;
            end
            WM_N:    n = (c == CH_A) ? WM_NA : WM_DEAD;
            WM_NA:   n = (c == CH_N) ? WM_NAN : WM_DEAD;
            WM_NAN:  n = (c == CH_F) ? WM_NANF : WM_DEAD;
            WM_SIGN: n = (c == CH_I) ? WM_I : WM_DEAD;
            WM_I:    n = (c == CH_N) ? WM_IN : WM_DEAD;
            WM_IN:   n = (c == CH_F) ? WM_INF : WM_DEAD;
            WM_INF:  n = (c == CH_F) ? WM_INFF : WM_DEAD;
            default: n = WM_DEAD;
        endcase
        return n;
    endfunction

endpackage

### design/slc_in_if.sv
// Character channel: one beat carries one character of a literal.
interface slc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;
    logic       empty_literal;

    modport source (output valid, output ch, output last, output empty_literal, input ready);
    modport sink   (input valid, input ch, input last, input empty_literal, output ready);
endinterface

### design/slc_out_if.sv
// Result channel: one beat carries the class of a finished literal.
interface slc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] literal_class;

    modport source (output valid, output literal_class, input ready);
    modport sink   (input valid, input literal_class, output ready);
endinterface

### design/slc_scan.sv
// Running scan state of the literal and its update for one character.
module slc_scan #(
    parameter int INT_MAX_CHARS = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                clear,
    input  logic [7:0]          ch,
    output slc_pkg::scan_t      scan
);
    localparam int CNT_SAT = INT_MAX_CHARS + 4;
    localparam int CNT_W   = $clog2(CNT_SAT + 1);
    localparam int WIDE_W  = slc_pkg::MAG_W + 4;

    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       first_quote_reg, first_quote_next;
    logic                       first_digit_reg, first_digit_next;
    logic                       third_quote_reg, third_quote_next;
    logic                       negative_reg, negative_next;
    logic [slc_pkg::MAG_W-1:0]  mag_reg, mag_next;
    logic                       int_ok_reg, int_ok_next;
    logic [1:0]                 number_reg, number_next;
    logic [2:0]                 prefix_reg, prefix_next;
    logic [3:0]                 word_reg, word_next;

    logic                       dig, sgn, dot, quote, count_zero;
    logic [WIDE_W-1:0]          mag_wide, mag_sum;

    assign dig        = (ch >= slc_pkg::CH_ZERO) && (ch <= slc_pkg::CH_NINE);
    assign sgn        = (ch == slc_pkg::CH_PLUS) || (ch == slc_pkg::CH_MINUS);
    assign dot        = (ch == slc_pkg::CH_DOT);
    assign quote      = (ch == slc_pkg::CH_QUOTE);
    assign count_zero = (count_reg == '0);

    assign mag_wide = {4'b0000, mag_reg};
    assign mag_sum  = (mag_wide << 3) + (mag_wide << 1) + WIDE_W'(ch[3:0]);

    always_comb
    begin
        first_quote_next = count_zero ? quote : first_quote_reg;
        first_digit_next = count_zero ? dig : first_digit_reg;
        negative_next    = count_zero ? (ch == slc_pkg::CH_MINUS) : negative_reg;
        int_ok_next      = count_zero ? (dig || sgn) : (int_ok_reg && dig);
        third_quote_next = (count_reg == CNT_W'(2)) ? quote : third_quote_reg;
        if (!dig)
            mag_next = mag_reg;
        else if (mag_sum > WIDE_W'(slc_pkg::MAG_MAX))
            mag_next = slc_pkg::MAG_MAX;
        else
            mag_next = mag_sum[slc_pkg::MAG_W-1:0];
        number_next = slc_pkg::next_number(number_reg, dig, sgn, dot);
        prefix_next = slc_pkg::next_prefix(prefix_reg, dig, sgn, dot);
        word_next   = slc_pkg::next_word(word_reg, ch);
        count_next  = (count_reg < CNT_W'(CNT_SAT)) ? count_reg + CNT_W'(1) : count_reg;
    end

    always_comb
    begin
        scan.len_one         = (count_next == CNT_W'(1));
        scan.len_three       = (count_next == CNT_W'(3));
        scan.len_fits_int    = (count_next <= CNT_W'(INT_MAX_CHARS));
        scan.first_was_quote = first_quote_next;
        scan.first_was_digit = first_digit_next;
        scan.third_was_quote = third_quote_next;
        scan.negative_sign   = negative_next;
        scan.magnitude       = mag_next;
        scan.int_shape_ok    = int_ok_next;
        scan.number_state    = number_next;
        scan.prefix_before   = prefix_reg;
        scan.word_state      = word_next;
        scan.is_f            = (ch == slc_pkg::CH_F);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            first_quote_reg <= 1'b0;
            first_digit_reg <= 1'b0;
            third_quote_reg <= 1'b0;
            negative_reg    <= 1'b0;
            mag_reg         <= '0;
            int_ok_reg      <= 1'b1;
            number_reg      <= slc_pkg::NS_START;
            prefix_reg      <= slc_pkg::PS_START;
            word_reg        <= slc_pkg::WM_START;
        end
        else if (clear)
        begin
            count_reg       <= '0;
            first_quote_reg <= 1'b0;
            first_digit_reg <= 1'b0;
            third_quote_reg <= 1'b0;
            negative_reg    <= 1'b0;
            mag_reg         <= '0;
            int_ok_reg      <= 1'b1;
            number_reg      <= slc_pkg::NS_START;
            prefix_reg      <= slc_pkg::PS_START;
            word_reg        <= slc_pkg::WM_START;
        end
        else if (step)
        begin
            count_reg       <= count_next;
            first_quote_reg <= first_quote_next;
            first_digit_reg <= first_digit_next;
            third_quote_reg <= third_quote_next;
            negative_reg    <= negative_next;
            mag_reg         <= mag_next;
            int_ok_reg      <= int_ok_next;
            number_reg      <= number_next;
            prefix_reg      <= prefix_next;
            word_reg        <= word_next;
        end
    end
endmodule

### design/slc_classify.sv
// Class decision for a literal from its final scan state.
module slc_classify (
    input  slc_pkg::scan_t scan,
    output logic [2:0]     literal_class
);
    logic int_in_range, float_shape, double_shape;

    assign int_in_range = scan.magnitude <= (scan.negative_sign ? slc_pkg::INT_NEG_LIM
                                                                : slc_pkg::INT_POS_LIM);
    assign float_shape  = (scan.word_state == slc_pkg::WM_NANF)
                       || (scan.word_state == slc_pkg::WM_INFF)
                       || (scan.prefix_before == slc_pkg::PS_START)
                       || (scan.prefix_before == slc_pkg::PS_INT)
                       || (scan.prefix_before == slc_pkg::PS_FRAC);
    assign double_shape = (scan.word_state == slc_pkg::WM_NAN)
                       || (scan.word_state == slc_pkg::WM_INF)
                       || (scan.number_state != slc_pkg::NS_DEAD);

    always_comb
    begin
        priority if (scan.len_one && !scan.first_was_digit)
            literal_class = slc_pkg::CLS_CHAR;
        else if (scan.len_three && scan.first_was_quote && scan.third_was_quote)
            literal_class = slc_pkg::CLS_CHAR;
        else if (scan.int_shape_ok && scan.len_fits_int && int_in_range)
            literal_class = slc_pkg::CLS_INT;
        else if (scan.is_f && float_shape)
            literal_class = slc_pkg::CLS_FLOAT;
        else if (double_shape)
            literal_class = slc_pkg::CLS_DOUBLE;
        else
            literal_class = slc_pkg::CLS_NONE;
    end
endmodule

### design/scalar_literal_classifier_core.sv
// Top level of the scalar literal classifier: input stage, scan state and result stage.
//
//  channel  | dir | payload                      | beats
//  ---------+-----+------------------------------+---------------------------------
//  item     | in  | ch[7:0], last, empty_literal | one per character
//  result   | out | literal_class[2:0]           | one per last or empty_literal beat
//
// One character per cycle unless a stalled result holds an ending beat; classes are registered.
// Both the character register and the class register fill and drain in the same cycle.
// The scan state update and the class decision sit between those two registers.
// Reset clears the scan state and both valid flags; no result is pending after reset.
// A stalled result holds only beats that end a literal; other characters keep flowing.
module scalar_literal_classifier_core #(
    parameter int INT_MAX_CHARS = 11
) (
    input  logic       clk,
    input  logic       rst_n,
    slc_in_if.sink     item,
    slc_out_if.source  result
);
    logic           in_valid_reg;
    logic [7:0]     in_ch_reg;
    logic           in_last_reg;
    logic           in_empty_reg;
    logic           out_valid_reg;
    logic [2:0]     class_reg;

    logic           ends_literal, advance;
    logic [2:0]     scan_class;
    slc_pkg::scan_t scan;

    assign ends_literal = in_last_reg || in_empty_reg;
    assign advance      = in_valid_reg && (!ends_literal || !out_valid_reg || result.ready);
    assign item.ready   = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item.ready)
            in_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            in_ch_reg    <= item.ch;
            in_last_reg  <= item.last;
            in_empty_reg <= item.empty_literal;
        end
    end

    slc_scan #(
        .INT_MAX_CHARS(INT_MAX_CHARS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance && !in_empty_reg),
        .clear (advance && ends_literal),
        .ch    (in_ch_reg),
        .scan  (scan)
    );

    slc_classify u_classify (
        .scan          (scan),
        .literal_class (scan_class)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && ends_literal)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && ends_literal)
            class_reg <= in_empty_reg ? slc_pkg::CLS_NONE : scan_class;
    end

    assign result.valid         = out_valid_reg;
    assign result.literal_class = class_reg;
endmodule

### design/slc_checker.sv
// Port-level checks for the scalar literal classifier and their bind.
module slc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic       item_last,
    input logic       item_empty_literal,
    input logic       result_valid,
    input logic       result_ready,
    input logic [2:0] literal_class
);
    logic [1:0] pending_reg, pending_next;
    logic       ends_in, beat_out;

    assign ends_in  = item_valid && item_ready && (item_last || item_empty_literal);
    assign beat_out = result_valid && result_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (ends_in && !beat_out)
            pending_next = pending_reg + 2'd1;
        else if (!ends_in && beat_out)
            pending_next = pending_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 2'd0;
        else
            pending_reg <= pending_next;
    end

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    a_class_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(literal_class))
        else $error("class changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pending_reg != 2'd0) && (literal_class <= slc_pkg::CLS_DOUBLE))
        else $error("result without an ending beat, or bad class");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 2'd2)
        else $error("more literals in flight than stages");
endmodule

bind scalar_literal_classifier_core slc_checker u_slc_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item.valid),
    .item_ready         (item.ready),
    .item_last          (item.last),
    .item_empty_literal (item.empty_literal),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .literal_class      (result.literal_class)
);
